[hdl/dswkh_pkg.sv]
// Shared constants and types for the dual sliding-window key histogram.
package dswkh_pkg;

    localparam int SHORT_WINDOW_DEF = 100;
    localparam int LONG_WINDOW_DEF  = 2000;
    localparam int NUM_LAYERS_DEF   = 4;
    localparam int NUM_LEDS_DEF     = 36;

    localparam int LAYER_W       = 2;
    localparam int LED_W         = 6;
    localparam int ENTRY_W       = LAYER_W + LED_W;
    localparam int SLOT_W        = 8;
    localparam int SHORT_COUNT_W = 7;
    localparam int LONG_COUNT_W  = 11;
    localparam int IN_DATA_W     = 8;
    localparam int OUT_DATA_W    = 24;

    // One counted key press as handed to each window.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic [ENTRY_W-1:0] entry;
    } key_req_t;

endpackage

[hdl/dual_sliding_window_key_histogram.sv]
// A result is offered from the output buffer once its item has passed stage 1 and stage 2.
// A new item is not taken while the previous one is in stage 1; this is set by the
// read-modify-write of the count memories (evicted key written back, then the pressed key).
// A two-entry output buffer lets items enter while results wait downstream.
// Reset clears ring heads, fill levels and count valid bits at once; ring
// memories are not cleared and no clearing pass is needed.
module dual_sliding_window_key_histogram #(
    parameter int SHORT_WINDOW = dswkh_pkg::SHORT_WINDOW_DEF,
    parameter int LONG_WINDOW  = dswkh_pkg::LONG_WINDOW_DEF,
    parameter int NUM_LAYERS   = dswkh_pkg::NUM_LAYERS_DEF,
    parameter int NUM_LEDS     = dswkh_pkg::NUM_LEDS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [dswkh_pkg::IN_DATA_W-1:0]     s_axis_tdata,  // layer[1:0], led[7:2]
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [dswkh_pkg::OUT_DATA_W-1:0]    m_axis_tdata   // accepted[0], short_count[7:1],
                                                               // long_count[18:8], zero[23:19]
);
    import dswkh_pkg::*;

    localparam int SCW = $clog2(SHORT_WINDOW + 1);
    localparam int LCW = $clog2(LONG_WINDOW + 1);
    localparam int RES_W = 1 + SHORT_COUNT_W + LONG_COUNT_W;

    logic [LAYER_W-1:0] layer, layer_cl;
    logic [LED_W-1:0]   led;
    logic               led_ok;
    logic               in_acc;
    logic               start;
    key_req_t           req;

    logic [SCW-1:0] short_cnt;
    logic [LCW-1:0] long_cnt;

    logic s1_vld_reg, s1_ok_reg;
    logic s2_vld_reg, s2_ok_reg;

    logic [RES_W-1:0] res;
    logic [RES_W-1:0] out0_reg, out0_next;
    logic [RES_W-1:0] out1_reg, out1_next;
    logic [1:0]       cnt_reg, cnt_next;
    logic             pop;

    assign layer = s_axis_tdata[LAYER_W-1:0];
    assign led   = s_axis_tdata[LAYER_W+LED_W-1:LAYER_W];

    assign layer_cl = ({1'b0, layer} >= 3'(NUM_LAYERS)) ? LAYER_W'(NUM_LAYERS - 1) : layer;
    assign led_ok   = led < LED_W'(NUM_LEDS);

    // an item may enter when stage 1 is free and the output buffer has room for it
    assign s_axis_tready = !s1_vld_reg && ((cnt_reg + {1'b0, s2_vld_reg}) < 2'd2);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign start         = in_acc && led_ok;

    assign req.slot  = SLOT_W'(layer_cl) * SLOT_W'(NUM_LEDS) + SLOT_W'(led);
    assign req.entry = {layer_cl, led};

    dswkh_window #(
        .DEPTH      (SHORT_WINDOW),
        .NUM_LAYERS (NUM_LAYERS),
        .NUM_LEDS   (NUM_LEDS)
    ) u_short (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .count (short_cnt)
    );

    dswkh_window #(
        .DEPTH      (LONG_WINDOW),
        .NUM_LAYERS (NUM_LAYERS),
        .NUM_LEDS   (NUM_LEDS)
    ) u_long (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .req   (req),
        .count (long_cnt)
    );

    assign res = s2_ok_reg ? {LONG_COUNT_W'(long_cnt), SHORT_COUNT_W'(short_cnt), 1'b1}
                           : '0;

    assign pop = m_axis_tvalid && m_axis_tready;

    always_comb
    begin
        out0_next = out0_reg;
        out1_next = out1_reg;
        cnt_next  = cnt_reg;
        case ({s2_vld_reg, pop})
            2'b01:
            begin
                out0_next = out1_reg;
                cnt_next  = cnt_reg - 1'b1;
            end
            2'b10:
            begin
                if (cnt_reg == 2'd0)
                begin
                    out0_next = res;
                end
                else
                begin
                    out1_next = res;
                end
                cnt_next = cnt_reg + 1'b1;
            end
            2'b11:
            begin
                if (cnt_reg == 2'd1)
                begin
                    out0_next = res;
                end
                else
                begin
                    out0_next = out1_reg;
                    out1_next = res;
                end
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            s1_vld_reg <= in_acc;
            s2_vld_reg <= s1_vld_reg;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_ok_reg <= led_ok;
        s2_ok_reg <= s1_ok_reg;
        out0_reg  <= out0_next;
        out1_reg  <= out1_next;
    end

    assign m_axis_tvalid = (cnt_reg != 2'd0);
    assign m_axis_tdata  = {(OUT_DATA_W - RES_W)'(0), out0_reg};

endmodule

[hdl/dswkh_ram.sv]
// Generic synchronous RAM: one write port, two registered read ports.
module dswkh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                      wr_data,
    input  logic                                  rd_en_a,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]                      rd_data_a,
    input  logic                                  rd_en_b,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]                      rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en_a)
        begin
            rd_data_a <= mem[rd_addr_a];
        end
        if (rd_en_b)
        begin
            rd_data_b <= mem[rd_addr_b];
        end
    end

endmodule

[hdl/dswkh_window.sv]
// One rolling window: history ring, per-key count table and its update pipeline.
module dswkh_window #(
    parameter int DEPTH      = 100,
    parameter int NUM_LAYERS = 4,
    parameter int NUM_LEDS   = 36
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  dswkh_pkg::key_req_t       req,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    import dswkh_pkg::*;

    localparam int HW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int SLOTS = NUM_LAYERS * NUM_LEDS;
    localparam int KAW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // ring position and fill level
    logic [HW-1:0] head_reg, head_next;
    logic [FW-1:0] fill_reg, fill_next;

    // stage 1: ring entry under the head is being read
    logic               s1_vld_reg;
    logic               s1_evict_reg;
    logic [KAW-1:0]     s1_slot_reg;
    logic [ENTRY_W-1:0] s1_entry_reg;
    logic [HW-1:0]      s1_head_reg;

    // stage 2: both counts are being read
    logic           s2_vld_reg;
    logic           s2_evict_reg;
    logic [KAW-1:0] s2_old_reg;
    logic [KAW-1:0] s2_new_reg;
    logic           s2_va_reg, s2_vb_reg;
    logic           s2_fa_reg, s2_fb_reg;
    logic [CW-1:0]  s2_fwd_reg;

    // stage 3: write back of the pressed key's count
    logic           s3_vld_reg;
    logic [KAW-1:0] s3_slot_reg;
    logic [CW-1:0]  s3_data_reg;

    logic [SLOTS-1:0] cvld_reg;

    logic [ENTRY_W-1:0] ring_rd;
    logic [CW-1:0]      cnt_rd_a, cnt_rd_b;

    logic [LAYER_W-1:0] old_layer;
    logic [LED_W-1:0]   old_led;
    logic [SLOT_W-1:0]  old_slot_full;
    logic [KAW-1:0]     old_slot;
    logic               old_ok;

    logic [CW-1:0]  oc, nc, base, newc;
    logic           same;
    logic           old_wr;
    logic           cnt_wr_en;
    logic [KAW-1:0] cnt_wr_addr;
    logic [CW-1:0]  cnt_wr_data;

    dswkh_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk       (clk),
        .wr_en     (s1_vld_reg),
        .wr_addr   (s1_head_reg),
        .wr_data   (s1_entry_reg),
        .rd_en_a   (start),
        .rd_addr_a (head_reg),
        .rd_data_a (ring_rd),
        .rd_en_b   (1'b0),
        .rd_addr_b (head_reg),
        .rd_data_b ()
    );

    dswkh_ram #(
        .WIDTH (CW),
        .DEPTH (SLOTS)
    ) u_counts (
        .clk       (clk),
        .wr_en     (cnt_wr_en),
        .wr_addr   (cnt_wr_addr),
        .wr_data   (cnt_wr_data),
        .rd_en_a   (s1_vld_reg),
        .rd_addr_a (old_slot),
        .rd_data_a (cnt_rd_a),
        .rd_en_b   (s1_vld_reg),
        .rd_addr_b (s1_slot_reg),
        .rd_data_b (cnt_rd_b)
    );

    always_comb
    begin
        head_next = head_reg;
        fill_next = fill_reg;
        if (start)
        begin
            head_next = (head_reg == HW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;
            if (fill_reg < FW'(DEPTH))
            begin
                fill_next = fill_reg + 1'b1;
            end
        end
    end

    // evicted key from the ring entry that comes back in stage 1
    assign old_layer     = ring_rd[ENTRY_W-1:LED_W];
    assign old_led       = ring_rd[LED_W-1:0];
    assign old_slot_full = SLOT_W'(old_layer) * SLOT_W'(NUM_LEDS) + SLOT_W'(old_led);
    assign old_slot      = old_slot_full[KAW-1:0];
    assign old_ok        = s1_evict_reg && ({1'b0, old_layer} < 3'(NUM_LAYERS))
                           && (old_led < LED_W'(NUM_LEDS));

    // stage 2 arithmetic; the stage-3 write of the previous item is forwarded
    always_comb
    begin
        oc   = s2_fa_reg ? s2_fwd_reg : (s2_va_reg ? cnt_rd_a : '0);
        nc   = s2_fb_reg ? s2_fwd_reg : (s2_vb_reg ? cnt_rd_b : '0);
        same = s2_evict_reg && (s2_old_reg == s2_new_reg);
        base = (same && nc != '0) ? nc - 1'b1 : nc;
        newc = (base < CW'(DEPTH)) ? base + 1'b1 : base;
        old_wr = s2_vld_reg && s2_evict_reg && !same && (oc != '0);
    end

    // stage-2 and stage-3 writes never fall in the same cycle while no item starts as the previous one is in stage 1
    always_comb
    begin
        cnt_wr_en   = s3_vld_reg || old_wr;
        cnt_wr_addr = s3_vld_reg ? s3_slot_reg : s2_old_reg;
        cnt_wr_data = s3_vld_reg ? s3_data_reg : oc - 1'b1;
    end

    assign count = newc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg   <= '0;
            fill_reg   <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            cvld_reg   <= '0;
        end
        else
        begin
            head_reg   <= head_next;
            fill_reg   <= fill_next;
            s1_vld_reg <= start;
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            if (cnt_wr_en)
            begin
                cvld_reg[cnt_wr_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            s1_evict_reg <= (fill_reg == FW'(DEPTH));
            s1_slot_reg  <= req.slot[KAW-1:0];
            s1_entry_reg <= req.entry;
            s1_head_reg  <= head_reg;
        end
        if (s1_vld_reg)
        begin
            s2_evict_reg <= old_ok;
            s2_old_reg   <= old_slot;
            s2_new_reg   <= s1_slot_reg;
            s2_va_reg    <= old_ok && cvld_reg[old_slot];
            s2_vb_reg    <= cvld_reg[s1_slot_reg];
            s2_fa_reg    <= s3_vld_reg && (s3_slot_reg == old_slot);
            s2_fb_reg    <= s3_vld_reg && (s3_slot_reg == s1_slot_reg);
            s2_fwd_reg   <= s3_data_reg;
        end
        if (s2_vld_reg)
        begin
            s3_slot_reg <= s2_new_reg;
            s3_data_reg <= newc;
        end
    end

endmodule
